// ===== rtl/pls_pkg.sv =====
// Shared types and constants for the positional list store.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
`timescale 1ns / 1ps

package pls_pkg;

  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 32;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Internal widths derived from the store size
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int EXT_W = (ITEM_BITS > VALUE_W) ? ITEM_BITS : VALUE_W;

  typedef logic [ITEM_BITS-1:0] item_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/positional_list_store_top.sv =====
// Positional list store: request register, one pass of compare/shift logic, result register.
// Depends on pls_pkg (sizes, opcode and status codes).
// Path: an accepted request waits in the request register, then moves into the result register
//   (out_valid high from then on) once that register is empty or being drained.
// Throughput: one request per cycle while results drain. While a result waits on out_ready,
//   an empty request register takes one more; once both are full, in_ready follows out_ready.
// Reset (rst_n low, synchronous): empties the list and drops any request or result in flight;
//   slot contents are left as they are and are only read below the item count.
`timescale 1ns / 1ps

module positional_list_store_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pls_pkg::OP_W-1:0]      in_operation,
  input  logic [pls_pkg::POS_W-1:0]     in_position,
  input  logic [pls_pkg::VALUE_W-1:0]   in_item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pls_pkg::STATUS_W-1:0]  out_status,
  output logic [pls_pkg::VALUE_W-1:0]   out_item_out,
  output logic [pls_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_empty_res
);

  // Request register
  logic                          req_valid_r;
  pls_pkg::op_t                  req_op_r;
  logic [pls_pkg::POS_W-1:0]     req_pos_r;
  pls_pkg::item_t                req_val_r;

  // List state: items in order at slots 0 .. held-1
  pls_pkg::item_t                slots_r   [pls_pkg::CAPACITY];
  pls_pkg::item_t                slots_nxt [pls_pkg::CAPACITY];
  logic [pls_pkg::CNT_W-1:0]     held_r, held_nxt;

  // Result register
  logic                          res_valid_r;
  pls_pkg::status_t              res_status_r, res_status_nxt;
  logic [pls_pkg::VALUE_W-1:0]   res_item_r, res_item_nxt;
  logic [pls_pkg::COUNT_W-1:0]   res_count_r;

  logic                          advance;
  logic                          take;
  logic [pls_pkg::CMP_W-1:0]     pos_ext, held_ext, pos_m1;
  logic [pls_pkg::IDX_W-1:0]     idx;
  logic                          pos_zero;
  logic                          do_insert, do_remove;
  logic [pls_pkg::EXT_W-1:0]     hit_ext;
  logic [pls_pkg::EXT_W-1:0]     val_ext;

  // The result register frees when empty or drained this cycle; the request
  // register frees when it is empty or its item moves into the result register.
  assign advance  = !res_valid_r || out_ready;
  assign in_ready = !req_valid_r || advance;
  assign take     = req_valid_r && advance;

  assign pos_ext  = pls_pkg::CMP_W'(req_pos_r);
  assign held_ext = pls_pkg::CMP_W'(held_r);
  assign pos_m1   = pos_ext - pls_pkg::CMP_W'(1);
  assign idx      = pos_m1[pls_pkg::IDX_W-1:0];
  assign pos_zero = (req_pos_r == '0);
  assign hit_ext  = pls_pkg::EXT_W'(slots_r[idx]);
  assign val_ext  = pls_pkg::EXT_W'(in_item_value);

  // Decide status and the item returned; the position check comes before the full check.
  always_comb begin
    res_status_nxt = pls_pkg::ST_RANGE;
    res_item_nxt   = '0;
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    case (req_op_r)
      pls_pkg::OP_INSERT: begin
        if (pos_zero || pos_ext > held_ext + pls_pkg::CMP_W'(1)) begin
          res_status_nxt = pls_pkg::ST_RANGE;
        end else if (held_ext >= pls_pkg::CMP_W'(pls_pkg::CAPACITY)) begin
          res_status_nxt = pls_pkg::ST_FULL;
        end else begin
          res_status_nxt = pls_pkg::ST_DONE;
          do_insert      = 1'b1;
        end
      end
      pls_pkg::OP_REMOVE, pls_pkg::OP_READ: begin
        if (pos_zero || pos_ext > held_ext) begin
          res_status_nxt = pls_pkg::ST_RANGE;
        end else begin
          res_status_nxt = pls_pkg::ST_DONE;
          res_item_nxt   = hit_ext[pls_pkg::VALUE_W-1:0];
          do_remove      = (req_op_r == pls_pkg::OP_REMOVE);
        end
      end
      default: begin
        res_status_nxt = pls_pkg::ST_RANGE;
      end
    endcase
  end

  // Shift every slot in parallel: up past the insert point, down from the remove point.
  always_comb begin
    for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
      slots_nxt[i] = slots_r[i];
      if (take && do_insert) begin
        if (pls_pkg::IDX_W'(i) == idx) begin
          slots_nxt[i] = req_val_r;
        end else if (pls_pkg::IDX_W'(i) > idx && i > 0) begin
          slots_nxt[i] = slots_r[(i > 0) ? i - 1 : 0];
        end
      end else if (take && do_remove) begin
        if (pls_pkg::IDX_W'(i) >= idx && i < pls_pkg::CAPACITY - 1) begin
          slots_nxt[i] = slots_r[(i < pls_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (take && do_insert) begin
      held_nxt = pls_pkg::CNT_W'(held_ext + pls_pkg::CMP_W'(1));
    end else if (take && do_remove) begin
      held_nxt = pls_pkg::CNT_W'(held_ext - pls_pkg::CMP_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= req_valid_r;
      end
      held_r <= held_nxt;
    end
  end

  // Payload: capture the request, hold the result while stalled
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_op_r  <= pls_pkg::op_t'(in_operation);
      req_pos_r <= in_position;
      req_val_r <= val_ext[pls_pkg::ITEM_BITS-1:0];
    end
    if (take) begin
      res_status_r <= res_status_nxt;
      res_item_r   <= res_item_nxt;
      res_count_r  <= pls_pkg::COUNT_W'(pls_pkg::CMP_W'(held_nxt));
    end
    for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
      slots_r[i] <= slots_nxt[i];
    end
  end

  assign out_valid     = res_valid_r;
  assign out_status    = res_status_r;
  assign out_item_out  = res_item_r;
  assign out_count     = res_count_r;
  assign out_empty_res = (res_count_r == '0);

endmodule

// ===== rtl/pls_checker.sv =====
// Port-level checks for positional_list_store_top, attached by bind.
// Depends on pls_pkg for the status codes and the capacity.
`timescale 1ns / 1ps

module pls_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pls_pkg::STATUS_W-1:0]  out_status,
  input logic [pls_pkg::VALUE_W-1:0]   out_item_out,
  input logic [pls_pkg::COUNT_W-1:0]   out_count,
  input logic                          out_empty_res
);

  // Empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // Rejected requests return no item
  a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pls_pkg::ST_DONE) |-> (out_item_out == '0))
    else $error("nonzero item on rejected request");

  // A full rejection is only given when the list holds its capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pls_pkg::ST_FULL)
      |-> (out_count == pls_pkg::COUNT_W'(pls_pkg::CAPACITY)))
    else $error("full status below capacity");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_item_out) && $stable(out_count))
    else $error("result changed while stalled");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_item_out  (out_item_out),
  .out_count     (out_count),
  .out_empty_res (out_empty_res)
);

// ===== bench/positional_list_store_top_tb.sv =====
// Self-checking bench for positional_list_store_top: directed table, then random requests.
// Depends on pls_pkg and the RTL top; expected results come from an in-bench list model or pinned rows.
`timescale 1ns / 1ps

module positional_list_store_top_tb;
  import pls_pkg::*;

  // Operation code 3 has no meaning; the store must answer it as out of range.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  item;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } list_result_t;

  // One line of the directed table; reps > 1 sends the same item again and again.
  // Typed-in results are used where pinned is set, the list model everywhere else.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  value;
    int                  reps;
    bit                  pinned;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  item;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [VALUE_W-1:0]  in_item_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_item_out;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty_res;

  // List model state: items in order at indices 0 .. list_count-1.
  item_t        list_slots [CAPACITY];
  int unsigned  list_count = 0;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  int unsigned  mismatches = 0;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  directed_row_t directed_rows [25];

  positional_list_store_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_item_out  (out_item_out),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  always #1 clk = ~clk;

  // Apply one request to the list model and return the result it must give.
  task automatic apply_list_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                    input logic [VALUE_W-1:0] val, output list_result_t res);
    int unsigned p;
    int unsigned i;
    p = 32'(pos);
    res.status = ST_RANGE;
    res.item   = '0;
    case (op)
      OP_INSERT: begin
        // Position check comes first, so a bad position on a full list is a range error.
        if (p >= 1 && p <= list_count + 1) begin
          if (list_count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (i = list_count; i > p - 1; i--) list_slots[i] = list_slots[i - 1];
            list_slots[p - 1] = item_t'(val);
            list_count++;
            res.status = ST_DONE;
          end
        end
      end
      OP_REMOVE, OP_READ: begin
        if (p >= 1 && p <= list_count) begin
          res.item = list_slots[p - 1];
          if (op == OP_REMOVE) begin
            for (i = p - 1; i + 1 < list_count; i++) list_slots[i] = list_slots[i + 1];
            list_count--;
          end
          res.status = ST_DONE;
        end
      end
      default: ;
    endcase
    res.count = list_count[COUNT_W-1:0];
    res.empty = (list_count == 0);
  endtask

  // Offer one item, hold it until taken, then record what it must produce.
  // Call right after a rising edge; valid stays high on return so back-to-back items
  // need no second assignment in the same step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val, input bit pinned,
                              input list_result_t pinned_res);
    list_result_t res;
    // Idle for a random stretch before offering the item.
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_item_value <= val;
    // Values read here are the ones present just before the edge.
    do @(posedge clk); while (!in_ready);
    apply_list_request(op, pos, val, res);
    pending_results.push_back(pinned ? pinned_res : res);
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every result taken with the oldest one outstanding.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d item %h count %0d",
               out_status, out_item_out, out_count);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_status);
          mismatches++;
        end
        if (out_item_out !== oldest_result.item) begin
          $error("item_out: expected %h, got %h", oldest_result.item, out_item_out);
          mismatches++;
        end
        if (out_count !== oldest_result.count) begin
          $error("count: expected %0d, got %0d", oldest_result.count, out_count);
          mismatches++;
        end
        if (out_empty_res !== oldest_result.empty) begin
          $error("empty_res: expected %0d, got %0d", oldest_result.empty, out_empty_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned  row;
    int unsigned  rep;
    int unsigned  phase;
    int unsigned  n;
    int unsigned  pick;
    int unsigned  ins_limit;
    int unsigned  rem_limit;
    bit           growing;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    list_result_t pinned_res;

    // Directed table. The list is walked through empty, bad positions, the undefined
    // operation, filling to capacity, insert when full, and draining back to empty.
    directed_rows = '{
      '{OP_READ,   5'd1,  32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_REMOVE, 5'd1,  32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_INSERT, 5'd0,  32'hDEAD_BEEF, 1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_INSERT, 5'd2,  32'h1111_1111, 1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_UNUSED, 5'd0,  32'hFFFF_FFFF, 1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_INSERT, 5'd1,  32'hFFFF_FFFF, 1,  1'b1, ST_DONE,  32'h0,         5'd1,  1'b0},
      '{OP_READ,   5'd1,  32'h0,         1,  1'b1, ST_DONE,  32'hFFFF_FFFF, 5'd1,  1'b0},
      '{OP_INSERT, 5'd1,  32'h0000_0000, 1,  1'b1, ST_DONE,  32'h0,         5'd2,  1'b0},
      '{OP_INSERT, 5'd3,  32'hA5A5_A5A5, 1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_INSERT, 5'd2,  32'h0F0F_0F0F, 1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_READ,   5'd4,  32'h0,         1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_READ,   5'd31, 32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd4,  1'b0},
      '{OP_UNUSED, 5'd2,  32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd4,  1'b0},
      '{OP_REMOVE, 5'd2,  32'h0,         1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_INSERT, 5'd1,  32'h1234_5678, 13, 1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_INSERT, 5'd17, 32'h5555_AAAA, 1,  1'b1, ST_FULL,  32'h0,         5'd16, 1'b0},
      '{OP_INSERT, 5'd18, 32'h5555_AAAA, 1,  1'b1, ST_RANGE, 32'h0,         5'd16, 1'b0},
      '{OP_INSERT, 5'd0,  32'h5555_AAAA, 1,  1'b1, ST_RANGE, 32'h0,         5'd16, 1'b0},
      '{OP_READ,   5'd16, 32'h0,         1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_READ,   5'd17, 32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd16, 1'b0},
      '{OP_REMOVE, 5'd16, 32'h0,         1,  1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_REMOVE, 5'd1,  32'h0,         14, 1'b0, ST_DONE,  32'h0,         5'd0,  1'b0},
      '{OP_REMOVE, 5'd1,  32'h0,         1,  1'b1, ST_DONE,  32'hFFFF_FFFF, 5'd0,  1'b1},
      '{OP_REMOVE, 5'd1,  32'h0,         1,  1'b1, ST_RANGE, 32'h0,         5'd0,  1'b1},
      '{OP_INSERT, 5'd1,  32'h8000_0001, 1,  1'b1, ST_DONE,  32'h0,         5'd1,  1'b0}
    };

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < $size(directed_rows); row++) begin
      pinned_res.status = directed_rows[row].status;
      pinned_res.item   = directed_rows[row].item;
      pinned_res.count  = directed_rows[row].count;
      pinned_res.empty  = directed_rows[row].empty;
      for (rep = 0; rep < directed_rows[row].reps; rep++)
        send_request(directed_rows[row].op, directed_rows[row].pos, directed_rows[row].value,
                     directed_rows[row].pinned, pinned_res);
    end

    // Random part, one idling pattern per phase: none, sender idle, receiver stalled, both.
    growing = 1'b0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (n = 0; n < 300; n++) begin
        // Alternate between growing and shrinking stretches so the list
        // swings between empty and full.
        if (n % 48 == 0) growing = ~growing;
        ins_limit = growing ? 55 : 25;
        rem_limit = growing ? 70 : 65;
        pick = $urandom_range(0, 99);
        val = $urandom;
        case ($urandom_range(0, 15))
          0: val = '0;
          1: val = '1;
          default: ;
        endcase
        if (pick < ins_limit) begin
          op  = OP_INSERT;
          pos = POS_W'($urandom_range(1, list_count + 1));
        end else if (pick < 85) begin
          op  = (pick < rem_limit) ? OP_REMOVE : OP_READ;
          pos = (list_count == 0) ? 5'd1 : POS_W'($urandom_range(1, list_count));
        end else begin
          // Noise: any operation code, any position the port can carry.
          op  = OP_W'($urandom_range(0, 3));
          pos = POS_W'($urandom_range(0, 31));
        end
        send_request(op, pos, val, 1'b0, pinned_res);
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow for the pipeline depth.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== positional_list_store_top.f =====
rtl/pls_pkg.sv
rtl/positional_list_store_top.sv
rtl/pls_checker.sv
bench/positional_list_store_top_tb.sv
